// ===== src/playfair_digraph_cipher_defines.svh =====
// Assertion macros for the digraph cipher block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS

`define PF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define PF_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define PF_ASSERT(label, clk, rst, prop, msg)

`define PF_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ===== src/pf_pkg.sv =====
// Shared types, constants and helper functions for the digraph cipher block.
// No dependencies; used by the front, back and top-level modules of the block.
`timescale 1ns / 1ps

package pf_pkg;

  localparam int LETTER_W    = 5;
  localparam int GRID        = 5;
  localparam int POS_W       = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 45;
  localparam int SQ_LOW_W    = 45;
  localparam int SQ_MID_W    = 40;
  localparam int SQ_HIGH_W   = 40;

  localparam logic [LETTER_W-1:0] LETTER_I      = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J      = 5'd9;
  localparam logic [LETTER_W-1:0] FILLER_RESET  = 5'd23;
  localparam logic [POS_W-1:0]    POS_FIRST     = 3'd0;
  localparam logic [POS_W-1:0]    POS_LAST      = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_SQ_LOW  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SQ_MID  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SQ_HIGH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILLER  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_DROP    = 3'd5;

  typedef logic [GRID-1:0][GRID-1:0][LETTER_W-1:0] square_t;

  typedef struct packed {
    square_t             square;
    logic                decrypt;
    logic [LETTER_W-1:0] fill;
    logic                drop;
  } cfg_t;

  typedef struct packed {
    logic [LETTER_W-1:0] a;
    logic [LETTER_W-1:0] b;
    logic                last;
  } pair_t;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                valid;
    logic                last;
    logic                bad;
  } result_t;

  function automatic logic [LETTER_W-1:0] fold_j(input logic [LETTER_W-1:0] c);
    return (c == LETTER_J) ? LETTER_I : c;
  endfunction

  function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] pos,
                                                input logic decrypt);
    logic [POS_W-1:0] r;
    if (decrypt) begin
      r = (pos == POS_FIRST) ? POS_LAST : pos - 3'd1;
    end else begin
      r = (pos == POS_LAST) ? POS_FIRST : pos + 3'd1;
    end
    return r;
  endfunction

endpackage

// ===== src/pf_queue.sv =====
// Small register FIFO used between the front and back units and at the output.
// No package dependencies.
`timescale 1ns / 1ps

module pf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_valid && !full;
  assign do_rd   = rd_pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/pf_front.sv =====
// Front unit: folds letters, holds the open letter and forms digraph requests.
// Depends on pf_pkg; feeds the digraph queue.
`timescale 1ns / 1ps

module pf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [pf_pkg::LETTER_W-1:0]   letter_code,
  input  logic                          end_of_text,
  input  pf_pkg::cfg_t                  cfg,
  output logic                          q_push,
  output pf_pkg::pair_t                 q_data,
  input  logic                          q_full
);

  logic [pf_pkg::LETTER_W-1:0] held_letter;
  logic [pf_pkg::LETTER_W-1:0] held_letter_next;
  logic                        held_valid;
  logic                        held_valid_next;
  logic                        pend_valid;
  pf_pkg::pair_t               pend;
  pf_pkg::pair_t               first;
  pf_pkg::pair_t               pad;
  logic                        first_v;
  logic                        pad_v;
  logic [pf_pkg::LETTER_W-1:0] letter;
  logic                        accept;

  assign letter = pf_pkg::fold_j(letter_code);
  assign full   = rst || pend_valid || q_full;
  assign accept = push && !full;

  always_comb begin
    first_v          = 1'b0;
    pad_v            = 1'b0;
    first            = '0;
    pad              = '0;
    held_letter_next = held_letter;
    held_valid_next  = held_valid;
    if (held_valid) begin
      first_v = 1'b1;
      if (!cfg.decrypt && held_letter == letter) begin
        first.a          = held_letter;
        first.b          = cfg.fill;
        held_letter_next = letter;
        held_valid_next  = 1'b1;
      end else begin
        first.a         = held_letter;
        first.b         = letter;
        held_valid_next = 1'b0;
      end
    end else begin
      held_letter_next = letter;
      held_valid_next  = 1'b1;
    end
    if (end_of_text && held_valid_next) begin
      pad_v           = 1'b1;
      pad.a           = held_letter_next;
      pad.b           = cfg.fill;
      pad.last        = 1'b1;
      held_valid_next = 1'b0;
    end
    first.last = end_of_text && !pad_v;
    if (end_of_text) begin
      held_letter_next = '0;
    end
  end

  assign q_push = pend_valid || (accept && (first_v || pad_v));
  assign q_data = pend_valid ? pend : (first_v ? first : pad);

  always_ff @(posedge clk) begin
    if (accept && first_v && pad_v) begin
      pend <= pad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_letter <= '0;
      held_valid  <= 1'b0;
      pend_valid  <= 1'b0;
    end else begin
      if (accept) begin
        held_letter <= held_letter_next;
        held_valid  <= held_valid_next;
      end
      if (pend_valid && !q_full) begin
        pend_valid <= 1'b0;
      end else if (accept && first_v && pad_v) begin
        pend_valid <= 1'b1;
      end
    end
  end

endmodule

// ===== src/pf_back.sv =====
// Back unit: locates both letters in the key square, substitutes, emits letters.
// Depends on pf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "playfair_digraph_cipher_defines.svh"

module pf_back (
  input  logic             clk,
  input  logic             rst,
  input  pf_pkg::cfg_t     cfg,
  input  logic             q_empty,
  input  pf_pkg::pair_t    q_data,
  output logic             q_pop,
  output logic             out_push,
  output pf_pkg::result_t  out_data,
  input  logic             out_full
);

  // lookup stage
  logic                     s1_valid;
  pf_pkg::pair_t            s1_pair;
  logic                     s1_fa;
  logic                     s1_fb;
  logic [pf_pkg::POS_W-1:0] s1_ra;
  logic [pf_pkg::POS_W-1:0] s1_ca;
  logic [pf_pkg::POS_W-1:0] s1_rb;
  logic [pf_pkg::POS_W-1:0] s1_cb;

  // emit stage
  logic                        s2_valid;
  logic                        s2_phase;
  logic [pf_pkg::LETTER_W-1:0] s2_res0;
  logic [pf_pkg::LETTER_W-1:0] s2_res1;
  logic                        s2_bad;
  logic                        s2_last;
  logic                        s2_drop0;
  logic                        s2_drop1;

  logic                     fa;
  logic                     fb;
  logic [pf_pkg::POS_W-1:0] ra;
  logic [pf_pkg::POS_W-1:0] ca;
  logic [pf_pkg::POS_W-1:0] rb;
  logic [pf_pkg::POS_W-1:0] cb;

  logic [pf_pkg::POS_W-1:0]    ora;
  logic [pf_pkg::POS_W-1:0]    oca;
  logic [pf_pkg::POS_W-1:0]    orb;
  logic [pf_pkg::POS_W-1:0]    ocb;
  logic [pf_pkg::LETTER_W-1:0] res0;
  logic [pf_pkg::LETTER_W-1:0] res1;
  logic                        found;
  logic                        drop_on;

  logic s2_step;
  logic s2_done;
  logic s2_free;
  logic s1_move;
  logic s1_free;
  logic cur_drop;
  logic cur_last;

  always_comb begin
    fa = 1'b0;
    fb = 1'b0;
    ra = '0;
    ca = '0;
    rb = '0;
    cb = '0;
    for (int r = pf_pkg::GRID - 1; r >= 0; r--) begin
      for (int c = pf_pkg::GRID - 1; c >= 0; c--) begin
        if (cfg.square[r][c] == q_data.a) begin
          fa = 1'b1;
          ra = pf_pkg::POS_W'(r);
          ca = pf_pkg::POS_W'(c);
        end
        if (cfg.square[r][c] == q_data.b) begin
          fb = 1'b1;
          rb = pf_pkg::POS_W'(r);
          cb = pf_pkg::POS_W'(c);
        end
      end
    end
  end

  always_comb begin
    found = s1_fa && s1_fb;
    ora   = s1_ra;
    oca   = s1_cb;
    orb   = s1_rb;
    ocb   = s1_ca;
    if (s1_ca == s1_cb) begin
      ora = pf_pkg::step_pos(s1_ra, cfg.decrypt);
      oca = s1_ca;
      orb = pf_pkg::step_pos(s1_rb, cfg.decrypt);
      ocb = s1_cb;
    end else if (s1_ra == s1_rb) begin
      ora = s1_ra;
      oca = pf_pkg::step_pos(s1_ca, cfg.decrypt);
      orb = s1_rb;
      ocb = pf_pkg::step_pos(s1_cb, cfg.decrypt);
    end
    res0 = found ? cfg.square[ora][oca] : s1_pair.a;
    res1 = found ? cfg.square[orb][ocb] : s1_pair.b;
  end

  assign drop_on = cfg.decrypt && cfg.drop;

  assign cur_drop = s2_phase ? s2_drop1 : s2_drop0;
  assign cur_last = s2_phase && s2_last;
  assign s2_step  = s2_valid && !out_full;
  assign s2_done  = s2_step && s2_phase;
  assign s2_free  = !s2_valid || s2_done;
  assign s1_move  = s1_valid && s2_free;
  assign s1_free  = !s1_valid || s1_move;
  assign q_pop    = !q_empty && s1_free;

  assign out_push        = s2_step && !(cur_drop && !cur_last);
  assign out_data.letter = s2_phase ? s2_res1 : s2_res0;
  assign out_data.valid  = !cur_drop;
  assign out_data.last   = cur_last;
  assign out_data.bad    = s2_bad;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_pair <= q_data;
      s1_fa   <= fa;
      s1_fb   <= fb;
      s1_ra   <= ra;
      s1_ca   <= ca;
      s1_rb   <= rb;
      s1_cb   <= cb;
    end
    if (s1_move) begin
      s2_res0  <= res0;
      s2_res1  <= res1;
      s2_bad   <= !found;
      s2_last  <= s1_pair.last;
      s2_drop0 <= drop_on && (res0 == cfg.fill);
      s2_drop1 <= drop_on && (res1 == cfg.fill);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s2_phase <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
        s2_phase <= 1'b0;
      end else if (s2_done) begin
        s2_valid <= 1'b0;
        s2_phase <= 1'b0;
      end else if (s2_step) begin
        s2_phase <= 1'b1;
      end
    end
  end

  `PF_ASSERT(a_s1_hold, clk, rst, s1_valid && !s2_free |=> s1_valid && $stable(s1_pair), "lookup stage overwritten while stalled")
  `PF_ASSERT(a_last_kept, clk, rst, s2_step && s2_phase && s2_last |-> out_push, "final letter of a message not emitted")
  `PF_ASSERT_NEVER(a_phase_idle, clk, rst, s2_phase && !s2_valid, "second letter phase without a digraph")

endmodule

// ===== src/playfair_digraph_cipher.sv =====
// Top level of the digraph cipher: configuration registers, front, queues, back.
// Depends on pf_pkg, pf_queue, pf_front and pf_back.
//
//   channel   direction  handshake           payload
//   letters   in         push / full         letter_code, end_of_text
//   results   out        pop / empty         out_letter, letter_valid, out_last, bad_letter
//   config    in         cfg_we              cfg_index, cfg_data
//
// One letter is accepted per cycle while the digraph queue has room; a letter that
// closes a doubled pair and ends the message queues two digraphs, and the front unit
// takes no letter until the second leaves its pending register. The back unit emits
// each digraph as two result letters, one letter per cycle while the output queue has
// room; the result side sets the rate. Full is held high during reset. Either side may stall freely.
`timescale 1ns / 1ps

module playfair_digraph_cipher #(
  parameter int PAIR_DEPTH = 4,
  parameter int OUT_DEPTH  = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [pf_pkg::LETTER_W-1:0]       letter_code,
  input  logic                              end_of_text,
  output logic                              empty,
  input  logic                              pop,
  output logic [pf_pkg::LETTER_W-1:0]       out_letter,
  output logic                              letter_valid,
  output logic                              out_last,
  output logic                              bad_letter,
  input  logic                              cfg_we,
  input  logic [pf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [pf_pkg::SQ_LOW_W-1:0]  sq_low;
  logic [pf_pkg::SQ_MID_W-1:0]  sq_mid;
  logic [pf_pkg::SQ_HIGH_W-1:0] sq_high;
  logic                         cipher_mode;
  logic [pf_pkg::LETTER_W-1:0]  filler_letter;
  logic                         drop_filler;
  pf_pkg::cfg_t                 cfg;

  logic            pq_push;
  pf_pkg::pair_t   pq_wdata;
  logic            pq_full;
  logic            pq_pop;
  pf_pkg::pair_t   pq_rdata;
  logic            pq_empty;
  logic            oq_push;
  pf_pkg::result_t oq_wdata;
  logic            oq_full;
  pf_pkg::result_t oq_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_low        <= '0;
      sq_mid        <= '0;
      sq_high       <= '0;
      cipher_mode   <= 1'b0;
      filler_letter <= pf_pkg::FILLER_RESET;
      drop_filler   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pf_pkg::CFG_SQ_LOW:  sq_low        <= cfg_data[pf_pkg::SQ_LOW_W-1:0];
        pf_pkg::CFG_SQ_MID:  sq_mid        <= cfg_data[pf_pkg::SQ_MID_W-1:0];
        pf_pkg::CFG_SQ_HIGH: sq_high       <= cfg_data[pf_pkg::SQ_HIGH_W-1:0];
        pf_pkg::CFG_MODE:    cipher_mode   <= cfg_data[0];
        pf_pkg::CFG_FILLER:  filler_letter <= cfg_data[pf_pkg::LETTER_W-1:0];
        pf_pkg::CFG_DROP:    drop_filler   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.square  = pf_pkg::square_t'({sq_high, sq_mid, sq_low});
  assign cfg.decrypt = cipher_mode;
  assign cfg.fill    = pf_pkg::fold_j(filler_letter);
  assign cfg.drop    = drop_filler;

  pf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .letter_code (letter_code),
    .end_of_text (end_of_text),
    .cfg         (cfg),
    .q_push      (pq_push),
    .q_data      (pq_wdata),
    .q_full      (pq_full)
  );

  pf_queue #(
    .WIDTH ($bits(pf_pkg::pair_t)),
    .DEPTH (PAIR_DEPTH)
  ) u_pair_q (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (pq_push),
    .wr_data  (pq_wdata),
    .full     (pq_full),
    .rd_pop   (pq_pop),
    .rd_data  (pq_rdata),
    .empty    (pq_empty)
  );

  pf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (pq_empty),
    .q_data   (pq_rdata),
    .q_pop    (pq_pop),
    .out_push (oq_push),
    .out_data (oq_wdata),
    .out_full (oq_full)
  );

  pf_queue #(
    .WIDTH ($bits(pf_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (oq_push),
    .wr_data  (oq_wdata),
    .full     (oq_full),
    .rd_pop   (pop),
    .rd_data  (oq_rdata),
    .empty    (empty)
  );

  assign out_letter   = oq_rdata.letter;
  assign letter_valid = oq_rdata.valid;
  assign out_last     = oq_rdata.last;
  assign bad_letter   = oq_rdata.bad;

endmodule

// ===== sim/playfair_checker.sv =====
// Checker for the digraph cipher: mirrors the configuration writes, predicts the
// result letters of every accepted request and compares them in order.
// Depends on pf_pkg for widths, register indexes and the result record.
`timescale 1ns / 1ps

module playfair_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic                           full,
  input  logic [pf_pkg::LETTER_W-1:0]    letter_code,
  input  logic                           end_of_text,
  input  logic                           empty,
  input  logic                           pop,
  input  logic [pf_pkg::LETTER_W-1:0]    out_letter,
  input  logic                           letter_valid,
  input  logic                           out_last,
  input  logic                           bad_letter,
  input  logic                           cfg_we,
  input  logic [pf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                             errors,
  output int                             outstanding,
  output int                             letters_taken,
  output int                             results_checked,
  output int                             bad_seen,
  output int                             dropped_seen
);

  logic [pf_pkg::LETTER_W-1:0] key_cell [25];
  logic                        decrypt_mode;
  logic [pf_pkg::LETTER_W-1:0] filler;
  logic                        drop_fill;
  logic [pf_pkg::LETTER_W-1:0] held;
  logic                        held_ok;

  logic [pf_pkg::LETTER_W-1:0] sub_letter [4];
  logic                        sub_bad [4];
  int                          sub_count;

  pf_pkg::result_t expected_letters [$];

  initial begin
    errors = 0;
    outstanding = 0;
    letters_taken = 0;
    results_checked = 0;
    bad_seen = 0;
    dropped_seen = 0;
  end

  task automatic report(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic bit locate(input logic [pf_pkg::LETTER_W-1:0] c, output int row,
                                output int col);
    locate = 1'b0;
    row = 0;
    col = 0;
    for (int i = 24; i >= 0; i--) begin
      if (key_cell[i] == c) begin
        row = i / pf_pkg::GRID;
        col = i % pf_pkg::GRID;
        locate = 1'b1;
      end
    end
  endfunction

  task automatic substitute(input logic [pf_pkg::LETTER_W-1:0] a,
                            input logic [pf_pkg::LETTER_W-1:0] b);
    int ra, ca, rb, cb, shift;
    bit fa, fb;
    logic [pf_pkg::LETTER_W-1:0] oa, ob;
    shift = decrypt_mode ? 4 : 1;
    fa = locate(a, ra, ca);
    fb = locate(b, rb, cb);
    if (!fa || !fb) begin
      oa = a;
      ob = b;
    end else if (ca == cb) begin
      oa = key_cell[((ra + shift) % pf_pkg::GRID) * pf_pkg::GRID + ca];
      ob = key_cell[((rb + shift) % pf_pkg::GRID) * pf_pkg::GRID + cb];
    end else if (ra == rb) begin
      oa = key_cell[ra * pf_pkg::GRID + (ca + shift) % pf_pkg::GRID];
      ob = key_cell[rb * pf_pkg::GRID + (cb + shift) % pf_pkg::GRID];
    end else begin
      oa = key_cell[ra * pf_pkg::GRID + cb];
      ob = key_cell[rb * pf_pkg::GRID + ca];
    end
    sub_letter[sub_count] = oa;
    sub_bad[sub_count] = !(fa && fb);
    sub_count++;
    sub_letter[sub_count] = ob;
    sub_bad[sub_count] = !(fa && fb);
    sub_count++;
  endtask

  task automatic encipher_request(input logic [pf_pkg::LETTER_W-1:0] code, input logic eot);
    logic [pf_pkg::LETTER_W-1:0] letter, fill;
    bit last, drop;
    pf_pkg::result_t r;
    letter = (code == pf_pkg::LETTER_J) ? pf_pkg::LETTER_I : code;
    fill = (filler == pf_pkg::LETTER_J) ? pf_pkg::LETTER_I : filler;
    sub_count = 0;
    if (held_ok) begin
      if (!decrypt_mode && held == letter) begin
        substitute(held, fill);
        held = letter;
      end else begin
        substitute(held, letter);
        held_ok = 1'b0;
      end
    end else begin
      held = letter;
      held_ok = 1'b1;
    end
    if (eot && held_ok) begin
      substitute(held, fill);
      held_ok = 1'b0;
    end
    if (eot) held = '0;
    for (int k = 0; k < sub_count; k++) begin
      last = eot && (k == sub_count - 1);
      drop = decrypt_mode && drop_fill && (sub_letter[k] == fill);
      if (!drop || last) begin
        r = '{sub_letter[k], !drop, last, sub_bad[k]};
        expected_letters = {expected_letters, r};
      end
    end
  endtask

  always @(posedge clk) begin : watch
    pf_pkg::result_t want;
    if (rst) begin
      foreach (key_cell[i]) key_cell[i] = '0;
      decrypt_mode = 1'b0;
      filler = pf_pkg::FILLER_RESET;
      drop_fill = 1'b0;
      held = '0;
      held_ok = 1'b0;
      expected_letters.delete();
      outstanding <= 0;
    end else begin
      if (pop && !empty) begin
        results_checked++;
        if (bad_letter) bad_seen++;
        if (!letter_valid) dropped_seen++;
        if (expected_letters.size() == 0) begin
          report($sformatf("result %0d arrived with nothing pending (letter %0d)",
                           results_checked, out_letter));
        end else begin
          want = expected_letters.pop_front();
          if (out_letter !== want.letter)
            report($sformatf("result %0d out_letter %0d, expected %0d",
                             results_checked, out_letter, want.letter));
          if (letter_valid !== want.valid)
            report($sformatf("result %0d letter_valid %0b, expected %0b",
                             results_checked, letter_valid, want.valid));
          if (out_last !== want.last)
            report($sformatf("result %0d out_last %0b, expected %0b",
                             results_checked, out_last, want.last));
          if (bad_letter !== want.bad)
            report($sformatf("result %0d bad_letter %0b, expected %0b",
                             results_checked, bad_letter, want.bad));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          pf_pkg::CFG_SQ_LOW:  for (int i = 0; i < 9; i++) key_cell[i] = cfg_data[5*i +: 5];
          pf_pkg::CFG_SQ_MID:  for (int i = 0; i < 8; i++) key_cell[9+i] = cfg_data[5*i +: 5];
          pf_pkg::CFG_SQ_HIGH: for (int i = 0; i < 8; i++) key_cell[17+i] = cfg_data[5*i +: 5];
          pf_pkg::CFG_MODE:    decrypt_mode = cfg_data[0];
          pf_pkg::CFG_FILLER:  filler = cfg_data[pf_pkg::LETTER_W-1:0];
          pf_pkg::CFG_DROP:    drop_fill = cfg_data[0];
          default: ;
        endcase
      end
      if (push && !full) begin
        letters_taken++;
        encipher_request(letter_code, end_of_text);
      end
      outstanding <= expected_letters.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the digraph cipher regression: clock, reset, request and pop traffic,
// register settings and the verdict. Depends on pf_pkg, playfair_checker and
// playfair_digraph_cipher.
`timescale 1ns / 1ps

module testbench;

  localparam int LIMIT = 200000;
  localparam int IDLE_PCT = 12;
  localparam int MID_PAD = pf_pkg::CFG_DATA_W - pf_pkg::SQ_MID_W;
  localparam int HIGH_PAD = pf_pkg::CFG_DATA_W - pf_pkg::SQ_HIGH_W;
  localparam logic [pf_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [pf_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 3'd7;

  logic                           clk = 0;
  logic                           rst = 1;
  logic                           push = 0;
  logic                           pop = 0;
  logic [pf_pkg::LETTER_W-1:0]    letter_code = '0;
  logic                           end_of_text = 0;
  logic                           cfg_we = 0;
  logic [pf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [pf_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                           full, empty, letter_valid, out_last, bad_letter;
  logic [pf_pkg::LETTER_W-1:0]    out_letter;

  int errors, outstanding, letters_taken, results_checked, bad_seen, dropped_seen;
  int cycles = 0;
  int settings_used = 0;
  bit steady = 0;
  logic [pf_pkg::LETTER_W-1:0] grid [25];

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  playfair_digraph_cipher DUT (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .letter_code(letter_code), .end_of_text(end_of_text),
    .empty(empty), .pop(pop), .out_letter(out_letter), .letter_valid(letter_valid),
    .out_last(out_last), .bad_letter(bad_letter),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  playfair_checker u_checker (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .letter_code(letter_code), .end_of_text(end_of_text),
    .empty(empty), .pop(pop), .out_letter(out_letter), .letter_valid(letter_valid),
    .out_last(out_last), .bad_letter(bad_letter),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding), .letters_taken(letters_taken),
    .results_checked(results_checked), .bad_seen(bad_seen), .dropped_seen(dropped_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    pop <= !rst && (steady || $urandom_range(99) >= IDLE_PCT);
  end

  task automatic send_letter(input logic [pf_pkg::LETTER_W-1:0] code, input logic eot);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    letter_code <= code;
    end_of_text <= eot;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_text(input string s, input bit finish);
    for (int i = 0; i < s.len(); i++)
      send_letter(pf_pkg::LETTER_W'(s[i] - "A"), finish && (i == s.len() - 1));
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pf_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [pf_pkg::CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic configure(input logic dec, input logic [pf_pkg::LETTER_W-1:0] fill,
                           input logic drop);
    logic [pf_pkg::CFG_DATA_W-1:0] lo, mid, hi;
    lo = '0;
    mid = '0;
    hi = '0;
    for (int i = 0; i < 9; i++) lo[5*i +: 5] = grid[i];
    for (int i = 0; i < 8; i++) begin
      mid[5*i +: 5] = grid[9+i];
      hi[5*i +: 5] = grid[17+i];
    end
    mid[pf_pkg::CFG_DATA_W-1:pf_pkg::SQ_MID_W] = MID_PAD'($urandom);
    hi[pf_pkg::CFG_DATA_W-1:pf_pkg::SQ_HIGH_W] = HIGH_PAD'($urandom);
    write_reg(pf_pkg::CFG_SQ_LOW, lo);
    write_reg(pf_pkg::CFG_SQ_MID, mid);
    write_reg(pf_pkg::CFG_SQ_HIGH, hi);
    write_reg(pf_pkg::CFG_MODE, pf_pkg::CFG_DATA_W'({$urandom, dec}));
    write_reg(pf_pkg::CFG_FILLER, pf_pkg::CFG_DATA_W'({$urandom, fill}));
    write_reg(pf_pkg::CFG_DROP, pf_pkg::CFG_DATA_W'({$urandom, drop}));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic standard_grid();
    for (int i = 0; i < 25; i++) grid[i] = pf_pkg::LETTER_W'(i < 9 ? i : i + 1);
  endtask

  task automatic shuffle_grid();
    logic [pf_pkg::LETTER_W-1:0] t;
    int j;
    standard_grid();
    for (int i = 24; i > 0; i--) begin
      j = $urandom_range(i);
      t = grid[i];
      grid[i] = grid[j];
      grid[j] = t;
    end
  endtask

  initial begin
    int len, pick, sent;
    logic [pf_pkg::LETTER_W-1:0] code, prev, fill;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_text("AB", 1'b1);
    settle();

    standard_grid();
    configure(1'b0, pf_pkg::FILLER_RESET, 1'b0);
    send_text("ABAFAGEAJI", 1'b0);
    send_text("LL", 1'b1);
    send_letter(5'd31, 1'b0);
    send_letter(5'd26, 1'b1);
    send_text("Q", 1'b1);
    settle();

    configure(1'b1, pf_pkg::FILLER_RESET, 1'b1);
    send_text("YZAA", 1'b0);
    send_text("ZY", 1'b1);
    send_text("K", 1'b0);
    settle();

    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, pf_pkg::CFG_DATA_W'({$urandom, $urandom}));
    configure(1'b0, pf_pkg::FILLER_RESET, 1'b0);
    send_text("M", 1'b1);
    settle();

    foreach (grid[i]) grid[i] = '1;
    configure(1'b0, 5'd31, 1'b0);
    send_letter(5'd31, 1'b1);
    settle();

    foreach (grid[i]) grid[i] = '0;
    configure(1'b1, 5'd0, 1'b1);
    send_letter(5'd0, 1'b0);
    send_letter(5'd0, 1'b1);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      steady = (phase == 3 || phase == 4);
      pick = $urandom_range(9);
      if (pick < 7) shuffle_grid();
      else if (pick < 9) foreach (grid[i]) grid[i] = pf_pkg::LETTER_W'($urandom);
      else foreach (grid[i]) grid[i] = pf_pkg::LETTER_W'($urandom_range(8));
      fill = ($urandom_range(9) < 8) ? grid[$urandom_range(24)] : pf_pkg::LETTER_W'($urandom);
      configure(1'($urandom_range(1)), fill, 1'($urandom_range(1)));
      sent = 0;
      prev = '0;
      while (sent < 20) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          pick = $urandom_range(99);
          if (pick < 15 && i > 0) code = prev;
          else if (pick < 90) code = grid[$urandom_range(24)];
          else if (pick < 95) code = pf_pkg::LETTER_J;
          else code = pf_pkg::LETTER_W'($urandom);
          send_letter(code, (i == len - 1) && ($urandom_range(9) != 0));
          prev = code;
          sent++;
        end
      end
      settle();
    end
    steady = 0;
    repeat (20) @(posedge clk);

    $display("Covered %0d letters over %0d register settings, both cipher modes.",
             letters_taken, settings_used);
    $display("Checked %0d result letters: %0d flagged not in square, %0d dropped fillers.",
             results_checked, bad_seen, dropped_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/pf_pkg.sv
src/pf_queue.sv
src/pf_front.sv
src/pf_back.sv
src/playfair_digraph_cipher.sv
sim/playfair_checker.sv
sim/testbench.sv
